// ----- hdl/kbd_pkg.sv -----
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared types, widths, key maps and register indexes of the keypad and
// button debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package kbd_pkg;

    // keymap geometry that has input bits and mapped keys
    localparam int MAP_ROWS    = 4;
    localparam int MAP_COLS    = 4;
    localparam int MAP_BUTTONS = 3;
    localparam int MAP_KEYS    = MAP_ROWS * MAP_COLS;

    // parameter defaults
    localparam int KEY_ROWS_DEF     = 4;
    localparam int KEY_COLS_DEF     = 4;
    localparam int BUTTON_COUNT_DEF = 3;

    // field widths
    localparam int MATRIX_W    = 16;
    localparam int BUTTON_W    = 3;
    localparam int TIME_W      = 32;
    localparam int CODE_W      = 5;
    localparam int CHAR_W      = 7;
    localparam int SRC_W       = 2;
    localparam int DEB_W       = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 8;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEYPAD_DEBOUNCE = 4'd0,
        REG_BUTTON_DEBOUNCE = 4'd1
    } cfg_reg_t;

    // keymap rows "123A", "456B", "789C", "*0#D"
    localparam logic [CHAR_W-1:0] KEYPAD_CHARS [MAP_KEYS] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    // buttons 0..2 map to 'A', '#', '*'
    localparam logic [CHAR_W-1:0] BUTTON_CHARS [MAP_BUTTONS] = '{7'h41, 7'h23, 7'h2A};

    // one registered poll after the keypad scan
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [BUTTON_W-1:0] pressed;
        logic [TIME_W-1:0]   now;
    } poll_t;

    // events of one poll: bit 0 keypad, bit i+1 button i
    typedef struct packed {
        logic [MAP_BUTTONS:0] mask;
        logic [CHAR_W-1:0]    key_char;
    } evt_t;

endpackage

`default_nettype wire

// ----- hdl/kbd_scan.sv -----
// ----------------------------------------------------------------------------
// kbd_scan
// Input register: takes a poll and stores the single-key code of the keypad
// matrix together with the button press bits and the timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd_scan #(
    parameter int KEY_ROWS = kbd_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS = kbd_pkg::KEY_COLS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [kbd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              poll_valid,
    input  wire logic                         poll_ready,
    output kbd_pkg::poll_t                    poll
);
    import kbd_pkg::*;

    localparam int ROWS = (KEY_ROWS < MAP_ROWS) ? KEY_ROWS : MAP_ROWS;
    localparam int COLS = (KEY_COLS < MAP_COLS) ? KEY_COLS : MAP_COLS;

    logic [MATRIX_W-1:0] levels;
    logic [MATRIX_W-1:0] hit;
    logic                one_hot;
    logic [CODE_W-1:0]   code_or;
    poll_t               poll_next;
    logic                valid_reg;
    poll_t               poll_reg;

    // key scan: pressed positions, exactly one of them gives its code
    always_comb begin
        levels  = s_tdata[MATRIX_W-1:0];
        hit     = '0;
        code_or = '0;
        for (int r = 0; r < MAP_ROWS; r++) begin
            for (int c = 0; c < MAP_COLS; c++) begin
                if (r < ROWS && c < COLS) begin
                    hit[r*MAP_COLS+c] = ~levels[r*MAP_COLS+c];
                end
            end
        end
        for (int p = 0; p < MAP_KEYS; p++) begin
            if (hit[p]) begin
                code_or = code_or | CODE_W'(p + 1);
            end
        end
        one_hot = (hit != '0) && ((hit & (hit - MATRIX_W'(1))) == '0);
        poll_next.code    = one_hot ? code_or : '0;
        poll_next.pressed = ~s_tdata[MATRIX_W +: BUTTON_W];
        poll_next.now     = s_tdata[MATRIX_W+BUTTON_W +: TIME_W];
    end

    assign s_tready   = !valid_reg || poll_ready;
    assign poll_valid = valid_reg;
    assign poll       = poll_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            poll_reg <= poll_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/kbd_debounce.sv -----
// ----------------------------------------------------------------------------
// kbd_debounce
// Debounce state of the keypad and the buttons; builds the event set of the
// poll in the input register and updates the state when the poll moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd_debounce #(
    parameter int BUTTON_COUNT = kbd_pkg::BUTTON_COUNT_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     poll_valid,
    output logic                          poll_ready,
    input  wire kbd_pkg::poll_t           poll,
    input  wire logic [kbd_pkg::DEB_W-1:0] keypad_hold_ms,
    input  wire logic [kbd_pkg::DEB_W-1:0] button_hold_ms,
    output logic                          evt_valid,
    input  wire logic                     evt_ready,
    output kbd_pkg::evt_t                 evt
);
    import kbd_pkg::*;

    localparam int NB = (BUTTON_COUNT < MAP_BUTTONS) ? BUTTON_COUNT : MAP_BUTTONS;
    localparam int KEY_IDX_W = $clog2(MAP_KEYS);

    logic [CODE_W-1:0]    k_sample_reg, k_stable_reg, k_stable_next;
    logic [TIME_W-1:0]    k_edge_reg, k_edge_next;
    logic [KEY_IDX_W-1:0] k_index;
    logic                 k_fire;
    logic                 b_sample_reg [NB];
    logic                 b_sample_next [NB];
    logic                 b_stable_reg [NB];
    logic                 b_stable_next [NB];
    logic [TIME_W-1:0]    b_edge_reg [NB];
    logic [TIME_W-1:0]    b_edge_next [NB];
    logic                 b_fire [NB];
    logic                 advance;

    // keypad debouncer
    always_comb begin
        k_edge_next   = (poll.code != k_sample_reg) ? poll.now : k_edge_reg;
        k_fire        = ((poll.now - k_edge_next) >= TIME_W'(keypad_hold_ms))
                        && (k_stable_reg != poll.code);
        k_stable_next = k_fire ? poll.code : k_stable_reg;
        k_index       = KEY_IDX_W'(poll.code - CODE_W'(1));
    end

    // button debouncers
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            b_sample_next[i] = poll.pressed[i];
            b_edge_next[i]   = (poll.pressed[i] != b_sample_reg[i]) ? poll.now
                                                                   : b_edge_reg[i];
            b_fire[i]        = ((poll.now - b_edge_next[i]) >= TIME_W'(button_hold_ms))
                               && (b_stable_reg[i] != poll.pressed[i]);
            b_stable_next[i] = b_fire[i] ? poll.pressed[i] : b_stable_reg[i];
        end
    end

    // event set: new key press, then buttons going pressed
    always_comb begin
        evt.mask     = '0;
        evt.mask[0]  = k_fire && (poll.code != '0);
        evt.key_char = KEYPAD_CHARS[k_index];
        for (int i = 0; i < NB; i++) begin
            evt.mask[i+1] = b_fire[i] && poll.pressed[i];
        end
    end

    assign advance    = poll_valid && evt_ready;
    assign poll_ready = evt_ready;
    assign evt_valid  = poll_valid && (evt.mask != '0);

    // state update when the poll leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_sample_reg <= '0;
            k_stable_reg <= '0;
            k_edge_reg   <= '0;
            for (int i = 0; i < NB; i++) begin
                b_sample_reg[i] <= 1'b0;
                b_stable_reg[i] <= 1'b0;
                b_edge_reg[i]   <= '0;
            end
        end else if (advance) begin
            k_sample_reg <= poll.code;
            k_stable_reg <= k_stable_next;
            k_edge_reg   <= k_edge_next;
            for (int i = 0; i < NB; i++) begin
                b_sample_reg[i] <= b_sample_next[i];
                b_stable_reg[i] <= b_stable_next[i];
                b_edge_reg[i]   <= b_edge_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/kbd_emit.sv -----
// ----------------------------------------------------------------------------
// kbd_emit
// Event register: holds the events of one poll and sends them one per
// transfer, keypad first, then buttons in order, tlast on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          evt_valid,
    output logic                               evt_ready,
    input  wire kbd_pkg::evt_t                 evt,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [kbd_pkg::M_TDATA_W-1:0]      m_tdata,  // key_char[6:0], pad
    output logic [kbd_pkg::SRC_W-1:0]          m_tuser,  // from_button[1:0]
    output logic                               m_tlast   // last_event
);
    import kbd_pkg::*;

    logic [MAP_BUTTONS:0] mask_reg, mask_next;
    logic [MAP_BUTTONS:0] sel, rest;
    logic [CHAR_W-1:0]    char_reg;
    logic [CHAR_W-1:0]    ch;
    logic [SRC_W-1:0]     src;

    // lowest pending event
    always_comb begin
        sel  = mask_reg & (~mask_reg + 1'b1);
        rest = mask_reg & ~sel;
        src  = '0;
        ch   = char_reg;
        for (int i = 1; i <= MAP_BUTTONS; i++) begin
            if (sel[i]) begin
                src = SRC_W'(i);
                ch  = BUTTON_CHARS[i-1];
            end
        end
    end

    assign m_tvalid  = (mask_reg != '0);
    assign m_tdata   = M_TDATA_W'(ch);
    assign m_tuser   = src;
    assign m_tlast   = (rest == '0);
    assign evt_ready = !m_tvalid || (m_tready && m_tlast);

    always_comb begin
        mask_next = mask_reg;
        if (evt_ready) begin
            mask_next = evt_valid ? evt.mask : '0;
        end else if (m_tready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_valid && evt_ready) begin
            char_reg <= evt.key_char;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/keypad_and_button_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// keypad_and_button_debouncer_top
// Debounced 4x4 matrix keypad and three buttons, emitting ASCII key events.
// ----------------------------------------------------------------------------
// A poll is taken whenever the event register can take its events; a poll
// that yields k events (0 to 4) keeps the input waiting until the event
// register has sent them, since it sends one event per transfer.
// With an idle output, polls that yield at most one event stream at one per
// cycle. The keypad counts only when exactly one key is down; key and
// button releases emit nothing. Debounce times are written over the cfg
// port (index 0 keypad, index 1 buttons, reset 20 ms); the user must write
// them only while the block is idle, which the block does not enforce. Other indexes are ignored.
`default_nettype none

module keypad_and_button_debouncer_top #(
    parameter int KEY_ROWS     = kbd_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS     = kbd_pkg::KEY_COLS_DEF,
    parameter int BUTTON_COUNT = kbd_pkg::BUTTON_COUNT_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kbd_pkg::DEB_W-1:0]       cfg_data,
    // polls
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // matrix_levels[15:0], button_levels[18:16], time_ms[50:19], pad
    input  wire logic [kbd_pkg::S_TDATA_W-1:0]   s_tdata,
    // events
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kbd_pkg::M_TDATA_W-1:0]        m_tdata,  // key_char[6:0], pad
    output logic [kbd_pkg::SRC_W-1:0]            m_tuser,  // from_button[1:0]
    output logic                                 m_tlast   // last_event
);
    import kbd_pkg::*;

    logic [DEB_W-1:0] keypad_deb_reg;
    logic [DEB_W-1:0] button_deb_reg;
    logic             poll_valid, poll_ready;
    poll_t            poll;
    logic             evt_valid, evt_ready;
    evt_t             evt;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keypad_deb_reg <= DEBOUNCE_RESET;
            button_deb_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_KEYPAD_DEBOUNCE) begin
                keypad_deb_reg <= cfg_data;
            end
            if (cfg_index == REG_BUTTON_DEBOUNCE) begin
                button_deb_reg <= cfg_data;
            end
        end
    end

    kbd_scan #(
        .KEY_ROWS (KEY_ROWS),
        .KEY_COLS (KEY_COLS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .poll_valid (poll_valid),
        .poll_ready (poll_ready),
        .poll       (poll)
    );

    kbd_debounce #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .poll_valid     (poll_valid),
        .poll_ready     (poll_ready),
        .poll           (poll),
        .keypad_hold_ms (keypad_deb_reg),
        .button_hold_ms (button_deb_reg),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt            (evt)
    );

    kbd_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTH
    // remaining events of a poll follow without a gap
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("event burst broken before tlast");

    // events of one poll come in source order
    a_source_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tuser > $past(m_tuser)))
        else $error("events of a poll out of order");

    // input stalls only behind a pending event
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no event pending");
`endif

endmodule

`default_nettype wire
